// ===== rtl/core/xcfd_pkg.sv =====
// Shared types, character codes and helpers for the XOR-checked frame deframer.
// No dependencies; every other file of the block but the RAM and the port checker uses this package.
package xcfd_pkg;

  // Default capacities
  localparam int LINE_CAPACITY_DEF     = 63;
  localparam int COMMAND_CAPACITY_DEF  = 15;
  localparam int ARGUMENT_CAPACITY_DEF = 31;

  // Field lengths never exceed 63, so 6 bits hold any of them
  localparam int LEN_W = 6;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_X_LO   = 8'h78;
  localparam logic [7:0] CH_X_UP   = 8'h58;

  localparam logic [8:0] SEQ_MAX   = 9'd255;
  localparam logic [8:0] SAT_VALUE = 9'd256;

  typedef enum logic [2:0] {
    PH_SEQ_START  = 3'd0,
    PH_SEQ_DIGITS = 3'd1,
    PH_COMMAND    = 3'd2,
    PH_ARGUMENT   = 3'd3,
    PH_HEX_START  = 3'd4,
    PH_HEX_ZERO   = 3'd5,
    PH_HEX_DIGITS = 3'd6,
    PH_HEX_DONE   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SHOW
  } back_state_t;

  // One committed frame, waiting for the back end
  typedef struct packed {
    logic [7:0]       seq;
    logic             bank;
    logic [LEN_W-1:0] cmd_len;
    logic [LEN_W-1:0] arg_len;
  } desc_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } qstat_t;

  // Store write from the front end
  typedef struct packed {
    logic             cmd_we;
    logic             arg_we;
    logic             bank;
    logic [LEN_W-1:0] index;
    logic [7:0]       data;
  } store_wr_t;

  // Store read from the back end
  typedef struct packed {
    logic             cmd_re;
    logic             arg_re;
    logic             bank;
    logic [LEN_W-1:0] index;
  } store_rd_t;

  function automatic logic is_dec_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Bit 4: valid hex digit, bits 3:0: its value
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  function automatic logic is_hex_phase(input phase_t p);
    return (p == PH_HEX_START) || (p == PH_HEX_ZERO) || (p == PH_HEX_DIGITS) ||
           (p == PH_HEX_DONE);
  endfunction

endpackage

// ===== rtl/core/xcfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module xcfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/xcfd_front.sv =====
// Front end: accepts received bytes, parses the frame and fills the text stores.
// Depends on xcfd_pkg; pushes one descriptor per valid frame into xcfd_queue.
module xcfd_front #(
  parameter int LINE_CAPACITY     = xcfd_pkg::LINE_CAPACITY_DEF,
  parameter int COMMAND_CAPACITY  = xcfd_pkg::COMMAND_CAPACITY_DEF,
  parameter int ARGUMENT_CAPACITY = xcfd_pkg::ARGUMENT_CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  input  xcfd_pkg::qstat_t    qstat,
  output logic                push,
  output xcfd_pkg::desc_t     push_desc,
  output xcfd_pkg::store_wr_t wr
);

  localparam int LW = $clog2(LINE_CAPACITY + 1);
  localparam int CW = $clog2(COMMAND_CAPACITY + 1);
  localparam int AW = (ARGUMENT_CAPACITY == 0) ? 1 : $clog2(ARGUMENT_CAPACITY + 1);

  logic             inside_frame, inside_frame_next;
  logic [LW-1:0]    line_length, line_length_next;
  xcfd_pkg::phase_t phase, phase_next;
  logic [8:0]       seq_value, seq_value_next;
  logic [7:0]       running_xor, running_xor_next;
  logic [8:0]       check_value, check_value_next;
  logic             frame_bad, frame_bad_next;
  logic [CW-1:0]    cmd_len, cmd_len_next;
  logic [AW-1:0]    arg_len, arg_len_next;
  logic             bank, bank_next;

  logic accept;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic [11:0] seq_prod;
    logic [12:0] hex_sum;
    logic [4:0]  hx;
    logic        frame_ok;

    inside_frame_next = inside_frame;
    line_length_next  = line_length;
    phase_next        = phase;
    seq_value_next    = seq_value;
    running_xor_next  = running_xor;
    check_value_next  = check_value;
    frame_bad_next    = frame_bad;
    cmd_len_next      = cmd_len;
    arg_len_next      = arg_len;
    bank_next         = bank;
    push              = 1'b0;
    push_desc         = '{seq: seq_value[7:0], bank: bank,
                          cmd_len: xcfd_pkg::LEN_W'(cmd_len),
                          arg_len: xcfd_pkg::LEN_W'(arg_len)};
    wr                = '{cmd_we: 1'b0, arg_we: 1'b0, bank: bank,
                          index: '0, data: rx_byte};

    seq_prod = ({3'd0, seq_value} << 3) + ({3'd0, seq_value} << 1) + {8'd0, rx_byte[3:0]};
    hx       = xcfd_pkg::hex_value(rx_byte);
    hex_sum  = ({4'd0, check_value} << 4) + {9'd0, hx[3:0]};
    frame_ok = !frame_bad && xcfd_pkg::is_hex_phase(phase) &&
               (check_value == {1'b0, running_xor}) && (cmd_len != '0);

    if (accept) begin
      if (rx_byte == xcfd_pkg::CH_DOLLAR) begin
        // restart the frame
        inside_frame_next = 1'b1;
        line_length_next  = '0;
        phase_next        = xcfd_pkg::PH_SEQ_START;
        seq_value_next    = '0;
        running_xor_next  = '0;
        check_value_next  = '0;
        frame_bad_next    = 1'b0;
        cmd_len_next      = '0;
        arg_len_next      = '0;
      end else if (inside_frame && rx_byte != xcfd_pkg::CH_CR) begin
        if (rx_byte != xcfd_pkg::CH_LF) begin
          if (line_length < LW'(LINE_CAPACITY)) begin
            line_length_next = line_length + 1'b1;
            if (!frame_bad) begin
              if (!xcfd_pkg::is_hex_phase(phase) && rx_byte == xcfd_pkg::CH_NUL) begin
                frame_bad_next = 1'b1;
              end else begin
                if (!xcfd_pkg::is_hex_phase(phase) && rx_byte != xcfd_pkg::CH_STAR)
                  running_xor_next = running_xor ^ rx_byte;
                unique case (phase)
                  xcfd_pkg::PH_SEQ_START, xcfd_pkg::PH_SEQ_DIGITS: begin
                    if (xcfd_pkg::is_dec_digit(rx_byte)) begin
                      seq_value_next = (seq_prod > 12'(xcfd_pkg::SAT_VALUE)) ?
                                       xcfd_pkg::SAT_VALUE : seq_prod[8:0];
                      phase_next     = xcfd_pkg::PH_SEQ_DIGITS;
                    end else if (rx_byte == xcfd_pkg::CH_COMMA &&
                                 phase == xcfd_pkg::PH_SEQ_DIGITS &&
                                 seq_value <= xcfd_pkg::SEQ_MAX) begin
                      phase_next = xcfd_pkg::PH_COMMAND;
                    end else begin
                      frame_bad_next = 1'b1;
                    end
                  end
                  xcfd_pkg::PH_COMMAND: begin
                    if (rx_byte == xcfd_pkg::CH_COMMA) begin
                      phase_next = xcfd_pkg::PH_ARGUMENT;
                    end else if (rx_byte == xcfd_pkg::CH_STAR) begin
                      if (cmd_len == '0) frame_bad_next = 1'b1;
                      phase_next = xcfd_pkg::PH_HEX_START;
                    end else if (cmd_len < CW'(COMMAND_CAPACITY)) begin
                      wr.cmd_we    = 1'b1;
                      wr.index     = xcfd_pkg::LEN_W'(cmd_len);
                      cmd_len_next = cmd_len + 1'b1;
                    end else begin
                      frame_bad_next = 1'b1;
                    end
                  end
                  xcfd_pkg::PH_ARGUMENT: begin
                    if (rx_byte == xcfd_pkg::CH_STAR) begin
                      phase_next = xcfd_pkg::PH_HEX_START;
                    end else if (arg_len < AW'(ARGUMENT_CAPACITY)) begin
                      wr.arg_we    = 1'b1;
                      wr.index     = xcfd_pkg::LEN_W'(arg_len);
                      arg_len_next = arg_len + 1'b1;
                    end else begin
                      frame_bad_next = 1'b1;
                    end
                  end
                  xcfd_pkg::PH_HEX_START, xcfd_pkg::PH_HEX_ZERO: begin
                    if (phase == xcfd_pkg::PH_HEX_START && rx_byte == xcfd_pkg::CH_ZERO) begin
                      check_value_next = '0;
                      phase_next       = xcfd_pkg::PH_HEX_ZERO;
                    end else if (phase == xcfd_pkg::PH_HEX_ZERO &&
                                 (rx_byte == xcfd_pkg::CH_X_LO ||
                                  rx_byte == xcfd_pkg::CH_X_UP)) begin
                      phase_next = xcfd_pkg::PH_HEX_DIGITS;
                    end else if (hx[4]) begin
                      check_value_next = (hex_sum > 13'(xcfd_pkg::SAT_VALUE)) ?
                                         xcfd_pkg::SAT_VALUE : hex_sum[8:0];
                      phase_next       = xcfd_pkg::PH_HEX_DIGITS;
                    end else begin
                      phase_next = xcfd_pkg::PH_HEX_DONE;
                    end
                  end
                  xcfd_pkg::PH_HEX_DIGITS: begin
                    if (hx[4]) begin
                      check_value_next = (hex_sum > 13'(xcfd_pkg::SAT_VALUE)) ?
                                         xcfd_pkg::SAT_VALUE : hex_sum[8:0];
                    end else begin
                      phase_next = xcfd_pkg::PH_HEX_DONE;
                    end
                  end
                  xcfd_pkg::PH_HEX_DONE: begin
                  end
                  default: begin
                  end
                endcase
              end
            end
          end else begin
            // overlong line: drop it
            inside_frame_next = 1'b0;
          end
        end else begin
          inside_frame_next = 1'b0;
          if (frame_ok) begin
            // commit the frame and move on to the other bank
            push      = 1'b1;
            bank_next = !bank;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame <= 1'b0;
      line_length  <= '0;
      phase        <= xcfd_pkg::PH_SEQ_START;
      seq_value    <= '0;
      running_xor  <= '0;
      check_value  <= '0;
      frame_bad    <= 1'b0;
      cmd_len      <= '0;
      arg_len      <= '0;
      bank         <= 1'b0;
    end else begin
      inside_frame <= inside_frame_next;
      line_length  <= line_length_next;
      phase        <= phase_next;
      seq_value    <= seq_value_next;
      running_xor  <= running_xor_next;
      check_value  <= check_value_next;
      frame_bad    <= frame_bad_next;
      cmd_len      <= cmd_len_next;
      arg_len      <= arg_len_next;
      bank         <= bank_next;
    end
  end

endmodule

// ===== rtl/core/xcfd_queue.sv =====
// Two-entry descriptor queue between the front and back ends.
// Depends on xcfd_pkg for the descriptor and status types.
module xcfd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  xcfd_pkg::desc_t  push_desc,
  input  logic             pop,
  output xcfd_pkg::desc_t  head,
  output xcfd_pkg::qstat_t qstat
);

  xcfd_pkg::desc_t entry [2];
  logic            wr_ptr, rd_ptr;
  logic [1:0]      count;

  assign head            = entry[rd_ptr];
  assign qstat.full      = (count == 2'd2);
  assign qstat.not_empty = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/core/xcfd_back.sv =====
// Back end: replays a committed frame from the text stores onto the output stream.
// Depends on xcfd_pkg; reads the head of xcfd_queue and releases it after the last byte.
module xcfd_back (
  input  logic                clk,
  input  logic                rst,
  input  xcfd_pkg::desc_t     head,
  input  xcfd_pkg::qstat_t    qstat,
  output logic                pop,
  output xcfd_pkg::store_rd_t rd,
  input  logic [7:0]          cmd_rdata,
  input  logic [7:0]          arg_rdata,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_seq,
  output logic [7:0]          out_text,
  output logic                out_arg,
  output logic                out_last
);

  localparam int IW = xcfd_pkg::LEN_W + 1;

  xcfd_pkg::back_state_t state, state_next;
  logic [IW-1:0]         idx, idx_next;
  logic                  arg_sel, arg_sel_next;
  logic                  last, last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= xcfd_pkg::BK_IDLE;
      idx     <= '0;
      arg_sel <= 1'b0;
      last    <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      arg_sel <= arg_sel_next;
      last    <= last_next;
    end
  end

  always_comb begin
    logic [IW-1:0] total;
    logic [IW-1:0] arg_idx;
    logic          in_cmd;

    total   = {1'b0, head.cmd_len} + {1'b0, head.arg_len};
    in_cmd  = idx < {1'b0, head.cmd_len};
    arg_idx = idx - {1'b0, head.cmd_len};

    state_next   = state;
    idx_next     = idx;
    arg_sel_next = arg_sel;
    last_next    = last;
    pop          = 1'b0;
    out_valid    = 1'b0;
    rd           = '{cmd_re: 1'b0, arg_re: 1'b0, bank: head.bank, index: '0};

    unique case (state)
      xcfd_pkg::BK_IDLE: begin
        idx_next = '0;
        if (qstat.not_empty) state_next = xcfd_pkg::BK_READ;
      end
      xcfd_pkg::BK_READ: begin
        rd.cmd_re    = in_cmd;
        rd.arg_re    = !in_cmd;
        rd.index     = in_cmd ? idx[xcfd_pkg::LEN_W-1:0] : arg_idx[xcfd_pkg::LEN_W-1:0];
        arg_sel_next = !in_cmd;
        last_next    = (idx + 1'b1) == total;
        state_next   = xcfd_pkg::BK_SHOW;
      end
      xcfd_pkg::BK_SHOW: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (last) begin
            pop        = 1'b1;
            state_next = xcfd_pkg::BK_IDLE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = xcfd_pkg::BK_READ;
          end
        end
      end
      default: state_next = xcfd_pkg::BK_IDLE;
    endcase
  end

  assign out_seq  = head.seq;
  assign out_text = arg_sel ? arg_rdata : cmd_rdata;
  assign out_arg  = arg_sel;
  assign out_last = last;

endmodule

// ===== rtl/core/xor_checked_frame_deframer_core.sv =====
// Top level of the XOR-checked frame deframer: front parser, descriptor queue,
// back replayer and two banked text stores. Depends on xcfd_pkg and all xcfd_* modules.
//
// Usage
//   Input stream (s_axis_*): one received byte per transaction. Frames look like
//   $seq,CMD[,arg]*XX followed by a newline; '$' restarts a frame, '\r' is skipped.
//   Output stream (m_axis_*): for each frame whose XOR checksum matches, the CMD
//   bytes then the arg bytes, one per transaction, tlast on the final byte.
//   tdata carries the sequence number and the character, tuser flags arg bytes.
// Flow
//   The parser takes one byte per cycle while the queue is not full. Each emitted
//   byte is read from a text store, then presented, as the stores read registered;
//   the back end passes through idle between frames. After the newline that commits
//   a frame, tvalid rises once the queue, the idle and the read state are passed.
// Buffering
//   Text is held in two banks; up to two committed frames wait in the queue.
//   With both banks waiting, tready drops until the back end finishes a frame.
// Reset and stalls
//   rst clears the parser, the queue and the output state; the stores need no
//   clearing. A stalled receiver holds the current output transaction steady.
module xor_checked_frame_deframer_core #(
  parameter int LINE_CAPACITY     = xcfd_pkg::LINE_CAPACITY_DEF,
  parameter int COMMAND_CAPACITY  = xcfd_pkg::COMMAND_CAPACITY_DEF,
  parameter int ARGUMENT_CAPACITY = xcfd_pkg::ARGUMENT_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] frame_seq, [15:8] text_byte
  output logic        m_axis_tuser,   // [0] in_argument
  output logic        m_axis_tlast    // last_of_frame
);

  // Each store holds two banks of one field's capacity
  localparam int ARG_SLOT  = (ARGUMENT_CAPACITY == 0) ? 1 : ARGUMENT_CAPACITY;
  localparam int CMD_DEPTH = 2 * COMMAND_CAPACITY;
  localparam int ARG_DEPTH = 2 * ARG_SLOT;
  localparam int CMD_AW    = $clog2(CMD_DEPTH);
  localparam int ARG_AW    = $clog2(ARG_DEPTH);
  localparam int SUM_W     = xcfd_pkg::LEN_W + 1;

  logic                push, pop;
  xcfd_pkg::desc_t     push_desc, head;
  xcfd_pkg::qstat_t    qstat;
  xcfd_pkg::store_wr_t wr;
  xcfd_pkg::store_rd_t rd;
  logic [7:0]          cmd_rdata, arg_rdata;
  logic [CMD_AW-1:0]   cmd_waddr, cmd_raddr;
  logic [ARG_AW-1:0]   arg_waddr, arg_raddr;
  logic [7:0]          out_seq, out_text;

  xcfd_front #(
    .LINE_CAPACITY     (LINE_CAPACITY),
    .COMMAND_CAPACITY  (COMMAND_CAPACITY),
    .ARGUMENT_CAPACITY (ARGUMENT_CAPACITY)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .rx_byte   (s_axis_tdata),
    .qstat     (qstat),
    .push      (push),
    .push_desc (push_desc),
    .wr        (wr)
  );

  xcfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // Bank one sits right above bank zero in each store
  assign cmd_waddr = CMD_AW'(wr.bank ? {1'b0, wr.index} + SUM_W'(COMMAND_CAPACITY)
                                     : {1'b0, wr.index});
  assign cmd_raddr = CMD_AW'(rd.bank ? {1'b0, rd.index} + SUM_W'(COMMAND_CAPACITY)
                                     : {1'b0, rd.index});
  assign arg_waddr = ARG_AW'(wr.bank ? {1'b0, wr.index} + SUM_W'(ARG_SLOT)
                                     : {1'b0, wr.index});
  assign arg_raddr = ARG_AW'(rd.bank ? {1'b0, rd.index} + SUM_W'(ARG_SLOT)
                                     : {1'b0, rd.index});

  xcfd_ram #(
    .WIDTH (8),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_ram (
    .clk   (clk),
    .we    (wr.cmd_we),
    .waddr (cmd_waddr),
    .wdata (wr.data),
    .re    (rd.cmd_re),
    .raddr (cmd_raddr),
    .rdata (cmd_rdata)
  );

  xcfd_ram #(
    .WIDTH (8),
    .DEPTH (ARG_DEPTH)
  ) u_arg_ram (
    .clk   (clk),
    .we    (wr.arg_we),
    .waddr (arg_waddr),
    .wdata (wr.data),
    .re    (rd.arg_re),
    .raddr (arg_raddr),
    .rdata (arg_rdata)
  );

  xcfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .rd        (rd),
    .cmd_rdata (cmd_rdata),
    .arg_rdata (arg_rdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_seq   (out_seq),
    .out_text  (out_text),
    .out_arg   (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_text, out_seq};

endmodule

// ===== rtl/core/xcfd_checker.sv =====
// Port-level checks for the XOR-checked frame deframer, bound to the top level.
// No package dependency; sees only the output stream ports.
module xcfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // Reset empties the output side
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // Text bytes are never NUL
  a_text_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[15:8] != 8'h00))
    else $error("NUL text byte emitted");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("valid dropped while stalled");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("payload changed while stalled");

endmodule

bind xor_checked_frame_deframer_core xcfd_checker u_xcfd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/xcfd_text_checker.sv =====
// Checker for the XOR-checked frame deframer: watches both streams and predicts
// the emitted text from the received bytes. Depends on xcfd_pkg for character codes.
module xcfd_text_checker
  import xcfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  input  logic        rx_ready,
  input  logic [7:0]  rx_data,
  input  logic        tx_valid,
  input  logic        tx_ready,
  input  logic [15:0] tx_data,
  input  logic        tx_user,
  input  logic        tx_last,
  output int          mismatch_count,
  output int          bytes_owed
);

  localparam int LINE_CAP    = LINE_CAPACITY_DEF;
  localparam int CMD_CAP     = COMMAND_CAPACITY_DEF;
  localparam int ARG_CAP     = ARGUMENT_CAPACITY_DEF;
  localparam int MAX_REPORTS = 10;
  localparam logic [7:0] DIGIT_NINE = 8'h39;

  typedef struct packed {
    logic [7:0] seq;
    logic       in_arg;
    logic [7:0] ch;
    logic       last;
  } text_item_t;

  text_item_t expected_text[$];

  // Shadow of the parser
  logic       frame_open;
  int         line_len;
  phase_t     phase;
  logic [8:0] seq_val;
  logic [7:0] xor_acc;
  logic [8:0] chk;
  logic       bad;
  logic [7:0] cmd_buf[CMD_CAP];
  int         cmd_len;
  logic [7:0] arg_buf[ARG_CAP];
  int         arg_len;

  function automatic int hex_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
    return -1;
  endfunction

  // Append one hex digit, saturating at 256 so an overflow never matches
  function automatic logic [8:0] hex_acc(input logic [8:0] acc, input int d);
    int v;
    v = int'(acc) * 16 + d;
    return (v > int'(SAT_VALUE)) ? SAT_VALUE : 9'(v);
  endfunction

  task automatic open_frame();
    frame_open = 1'b1;
    line_len   = 0;
    phase      = PH_SEQ_START;
    seq_val    = '0;
    xor_acc    = '0;
    chk        = '0;
    bad        = 1'b0;
    cmd_len    = 0;
    arg_len    = 0;
  endtask

  // Advance the shadow parser by one received byte; queue the text of a good frame
  task automatic parse_rx_byte(input logic [7:0] c);
    int v;
    int d;
    int total;
    text_item_t item;
    if (c == CH_DOLLAR) begin
      open_frame();
      return;
    end
    if (!frame_open || c == CH_CR) return;
    if (c != CH_LF) begin
      if (line_len >= LINE_CAP) begin
        frame_open = 1'b0;
        return;
      end
      line_len++;
      if (bad) return;
      if (phase <= PH_ARGUMENT && c == CH_NUL) begin
        bad = 1'b1;
        return;
      end
      if (phase <= PH_ARGUMENT && c != CH_STAR) xor_acc ^= c;
      d = hex_of(c);
      case (phase)
        PH_SEQ_START, PH_SEQ_DIGITS: begin
          if (c >= CH_ZERO && c <= DIGIT_NINE) begin
            v = int'(seq_val) * 10 + int'(c - CH_ZERO);
            seq_val = (v > int'(SAT_VALUE)) ? SAT_VALUE : 9'(v);
            phase = PH_SEQ_DIGITS;
          end else if (c == CH_COMMA && phase == PH_SEQ_DIGITS && seq_val <= SEQ_MAX) begin
            phase = PH_COMMAND;
          end else begin
            bad = 1'b1;
          end
        end
        PH_COMMAND: begin
          if (c == CH_COMMA) begin
            phase = PH_ARGUMENT;
          end else if (c == CH_STAR) begin
            if (cmd_len == 0) bad = 1'b1;
            phase = PH_HEX_START;
          end else if (cmd_len < CMD_CAP) begin
            cmd_buf[cmd_len] = c;
            cmd_len++;
          end else begin
            bad = 1'b1;
          end
        end
        PH_ARGUMENT: begin
          if (c == CH_STAR) begin
            phase = PH_HEX_START;
          end else if (arg_len < ARG_CAP) begin
            arg_buf[arg_len] = c;
            arg_len++;
          end else begin
            bad = 1'b1;
          end
        end
        PH_HEX_START: begin
          if (c == CH_ZERO) begin
            chk = '0;
            phase = PH_HEX_ZERO;
          end else if (d >= 0) begin
            chk = hex_acc(chk, d);
            phase = PH_HEX_DIGITS;
          end else begin
            phase = PH_HEX_DONE;
          end
        end
        PH_HEX_ZERO: begin
          if (c == CH_X_LO || c == CH_X_UP) begin
            phase = PH_HEX_DIGITS;
          end else if (d >= 0) begin
            chk = hex_acc(chk, d);
            phase = PH_HEX_DIGITS;
          end else begin
            phase = PH_HEX_DONE;
          end
        end
        PH_HEX_DIGITS: begin
          if (d >= 0) chk = hex_acc(chk, d);
          else phase = PH_HEX_DONE;
        end
        default: ;
      endcase
      return;
    end
    // Newline: commit or drop
    frame_open = 1'b0;
    if (bad || phase < PH_HEX_START || chk != {1'b0, xor_acc} || cmd_len == 0) return;
    total = cmd_len + arg_len;
    for (int i = 0; i < cmd_len; i++) begin
      item = '{seq: seq_val[7:0], in_arg: 1'b0, ch: cmd_buf[i], last: (i + 1 == total)};
      expected_text.push_back(item);
    end
    for (int i = 0; i < arg_len; i++) begin
      item = '{seq: seq_val[7:0], in_arg: 1'b1, ch: arg_buf[i],
               last: (cmd_len + i + 1 == total)};
      expected_text.push_back(item);
    end
  endtask

  always @(posedge clk) begin : watch
    text_item_t got;
    text_item_t want;
    if (rst) begin
      open_frame();
      frame_open = 1'b0;
      expected_text.delete();
      mismatch_count = 0;
    end else begin
      // Compare output first: new expectations only ever land behind it
      if (tx_valid && tx_ready) begin
        got = '{seq: tx_data[7:0], in_arg: tx_user, ch: tx_data[15:8], last: tx_last};
        if (expected_text.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected output seq=%0d arg=%0b byte=%02h last=%0b",
                     $time, got.seq, got.in_arg, got.ch, got.last);
        end else begin
          want = expected_text.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t: expected %0d/%0b/%02h/%0b got %0d/%0b/%02h/%0b",
                       $time, want.seq, want.in_arg, want.ch, want.last,
                       got.seq, got.in_arg, got.ch, got.last);
          end
        end
      end
      if (rx_valid && rx_ready) parse_rx_byte(rx_data);
    end
    bytes_owed = expected_text.size();
  end

endmodule

// ===== tb/xor_checked_frame_deframer_core_tb.sv =====
// Testbench top for the XOR-checked frame deframer: drives received bytes with
// random gaps and output stalls, and reports the verdict. Depends on xcfd_pkg,
// xcfd_text_checker and the block itself.
module xor_checked_frame_deframer_core_tb;
  import xcfd_pkg::*;

  typedef logic [7:0] octet_q_t[$];

  typedef enum int {
    HX_UPPER,
    HX_LOWER,
    HX_PREFIX_LO,
    HX_PREFIX_UP,
    HX_SHORT,
    HX_PADDED
  } check_style_t;

  localparam int TOTAL_ITEMS  = 180;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int       mismatch_count;
  int       bytes_owed;
  int       idle_cycles;
  int       sent_items;
  int       hold_left;
  bit       calm;
  octet_q_t no_tail;

  xor_checked_frame_deframer_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  xcfd_text_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .rx_valid       (s_axis_tvalid),
    .rx_ready       (s_axis_tready),
    .rx_data        (s_axis_tdata),
    .tx_valid       (m_axis_tvalid),
    .tx_ready       (m_axis_tready),
    .tx_data        (m_axis_tdata),
    .tx_user        (m_axis_tuser),
    .tx_last        (m_axis_tlast),
    .mismatch_count (mismatch_count),
    .bytes_owed     (bytes_owed)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_text(ref octet_q_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  // Random text bytes that never end a field or the frame
  function automatic void push_random(ref octet_q_t q, input int n, input bit comma_ok);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      if (comma_ok && $urandom_range(0, 7) == 0) begin
        c = CH_COMMA;
      end else begin
        do c = 8'($urandom_range(1, 255));
        while (c == CH_DOLLAR || c == CH_STAR || c == CH_LF || c == CH_CR || c == CH_COMMA);
      end
      q.push_back(c);
    end
  endfunction

  // seq, comma, CMD, then an optional comma and arg (arg_n < 0 leaves it out)
  function automatic void make_body(ref octet_q_t body, input string seq_txt,
                                    input int cmd_n, input int arg_n);
    push_text(body, seq_txt);
    body.push_back(CH_COMMA);
    push_random(body, cmd_n, 1'b0);
    if (arg_n >= 0) begin
      body.push_back(CH_COMMA);
      push_random(body, arg_n, 1'b1);
    end
  endfunction

  function automatic string check_text(input logic [7:0] v, input check_style_t style);
    case (style)
      HX_UPPER:     return $sformatf("%02X", v);
      HX_LOWER:     return $sformatf("%02x", v);
      HX_PREFIX_LO: return $sformatf("0x%02X", v);
      HX_PREFIX_UP: return $sformatf("0X%02x", v);
      HX_SHORT:     return $sformatf("%0X", v);
      default:      return $sformatf("00%02X", v);
    endcase
  endfunction

  // Present one byte and hold it until the transaction completes; entered at negedge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Send a byte string, now and then slipping in a carriage return
  task automatic send_bytes(input octet_q_t q);
    foreach (q[i]) begin
      if ($urandom_range(0, 19) == 0) send_byte(CH_CR);
      send_byte(q[i]);
      sent_items++;
    end
  endtask

  task automatic send_text(input string s);
    octet_q_t q;
    push_text(q, s);
    send_bytes(q);
  endtask

  // Wrap a body as $body*XX<tail><newline>; corrupt flips the checksum
  task automatic send_checked(input octet_q_t body, input check_style_t style,
                              input bit corrupt, input octet_q_t tail);
    octet_q_t line;
    logic [7:0] sum;
    sum = '0;
    foreach (body[i]) sum ^= body[i];
    if (corrupt) sum ^= 8'($urandom_range(1, 255));
    line.push_back(CH_DOLLAR);
    foreach (body[i]) line.push_back(body[i]);
    line.push_back(CH_STAR);
    push_text(line, check_text(sum, style));
    foreach (tail[i]) line.push_back(tail[i]);
    line.push_back(CH_LF);
    send_bytes(line);
  endtask

  // Receiver stalls, independent of tvalid
  initial begin
    m_axis_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        hold_left = pick_gap();
        m_axis_tready = (hold_left == 0);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Watchdog: end the run if no transaction happens on either side for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    octet_q_t body;
    octet_q_t tail;
    octet_q_t line;
    string    seq_txt;
    int       cmd_n;
    int       arg_n;
    int       kind;
    int       cut;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    calm          = 1'b0;
    sent_items    = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: bytes before any '$' are dropped
    send_text("zz,A*00\n");

    // Full-size fields at seq 255 with a padded tail: exactly a full line passes
    body.delete();
    make_body(body, "255", COMMAND_CAPACITY_DEF, ARGUMENT_CAPACITY_DEF);
    tail.delete();
    push_text(tail, "       ");
    send_checked(body, HX_PADDED, 1'b0, tail);

    // Bad seq: a sign before the digits
    body.delete(); make_body(body, "+5", 2, -1); send_checked(body, HX_UPPER, 1'b0, no_tail);

    // NUL before the star drops the frame
    body.delete(); make_body(body, "8", 2, 1); body.push_back(CH_NUL);
    send_checked(body, HX_UPPER, 1'b0, no_tail);

    // Saturating checksum never matches
    send_text("$1,A*1FF\n");

    // XOR of zero matches an empty check value
    body.delete(); push_text(body, "0,"); body.push_back(8'h1C);
    line.delete(); line.push_back(CH_DOLLAR);
    foreach (body[i]) line.push_back(body[i]);
    push_text(line, "*\n");
    send_bytes(line);

    // '$' restarts a half-sent frame
    send_text("$1,AB");
    body.delete(); make_body(body, "2", 2, 2); send_checked(body, HX_UPPER, 1'b0, no_tail);

    // Random part: mostly well-formed frames with random content, some broken ones
    while (sent_items < TOTAL_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 15) == 0)
        seq_txt = $sformatf("%0d", $urandom_range(256, 999));
      else if ($urandom_range(0, 3) == 0)
        seq_txt = $sformatf("%03d", $urandom_range(0, 255));
      else
        seq_txt = $sformatf("%0d", $urandom_range(0, 255));
      cmd_n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, COMMAND_CAPACITY_DEF)
                                         : $urandom_range(1, 5);
      if ($urandom_range(0, 3) == 0)
        arg_n = -1;
      else if ($urandom_range(0, 7) == 0)
        arg_n = $urandom_range(0, ARGUMENT_CAPACITY_DEF);
      else
        arg_n = $urandom_range(0, 6);
      body.delete();
      tail.delete();
      make_body(body, seq_txt, cmd_n, arg_n);
      if ($urandom_range(0, 5) == 0) push_random(tail, $urandom_range(1, 3), 1'b1);
      if (kind < 70) begin
        send_checked(body, check_style_t'($urandom_range(HX_UPPER, HX_PADDED)),
                     $urandom_range(0, 9) == 0, tail);
      end else if (kind < 82) begin
        // Hit one byte of the body with any value at all
        body[$urandom_range(0, body.size() - 1)] = 8'($urandom_range(0, 255));
        send_checked(body, check_style_t'($urandom_range(HX_UPPER, HX_PADDED)), 1'b0, tail);
      end else if (kind < 91) begin
        line.delete();
        repeat ($urandom_range(1, 8)) line.push_back(8'($urandom_range(0, 255)));
        send_bytes(line);
      end else begin
        // Truncated frame; the next '$' restarts
        line.delete();
        line.push_back(CH_DOLLAR);
        cut = $urandom_range(1, body.size());
        for (int i = 0; i < cut; i++) line.push_back(body[i]);
        send_bytes(line);
      end
    end
    calm = 1'b0;
    s_axis_tvalid = 1'b0;

    // Drain, then give stray output a chance to show up
    while (bytes_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && bytes_owed == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/xcfd_pkg.sv
rtl/core/xcfd_ram.sv
rtl/core/xcfd_front.sv
rtl/core/xcfd_queue.sv
rtl/core/xcfd_back.sv
rtl/core/xor_checked_frame_deframer_core.sv
rtl/core/xcfd_checker.sv
tb/xcfd_text_checker.sv
tb/xor_checked_frame_deframer_core_tb.sv
